[rtl/rect_hit_test_table_defines.svh]
`ifndef RECT_HIT_TEST_TABLE_DEFINES_SVH
`define RECT_HIT_TEST_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RHT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define RHT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rht_pkg.sv]
`timescale 1ns / 1ps
package rht_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int COORD_BITS    = 20;
	localparam int TAG_BITS      = 32;
	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int SLOT_BITS     = 6;
	localparam int OPC_BITS      = 2;
	localparam int AREA_BITS     = 2 * COORD_BITS;

	localparam logic [OPC_BITS-1:0] OP_WRITE  = 2'd0;
	localparam logic [OPC_BITS-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPC_BITS-1:0] OP_HIT    = 2'd2;
	localparam logic [OPC_BITS-1:0] OP_FIND   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} rht_state_t;

	typedef struct packed {
		logic [OPC_BITS-1:0]          opcode;
		logic [SLOT_BITS-1:0]         slot;
		logic signed [COORD_BITS-1:0] left_edge;
		logic signed [COORD_BITS-1:0] top_edge;
		logic signed [COORD_BITS-1:0] right_edge;
		logic signed [COORD_BITS-1:0] bottom_edge;
		logic [TAG_BITS-1:0]          entry_tag;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic [TAG_BITS-1:0]          query_tag;
	} rht_req_t;

	typedef struct packed {
		logic                 found;
		logic [SLOT_BITS-1:0] match_slot;
		logic [TAG_BITS-1:0]  match_tag;
	} rht_rsp_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] left_edge;
		logic signed [COORD_BITS-1:0] top_edge;
		logic signed [COORD_BITS-1:0] right_edge;
		logic signed [COORD_BITS-1:0] bottom_edge;
		logic [TAG_BITS-1:0]          tag;
	} rht_entry_t;

	typedef struct packed {
		logic                  hit;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
		logic [IDX_BITS-1:0]   idx;
		logic [TAG_BITS-1:0]   tag;
	} rht_cand_t;

	typedef struct packed {
		logic                hit;
		logic [IDX_BITS-1:0] idx;
		logic [TAG_BITS-1:0] tag;
	} rht_best_t;

endpackage

[rtl/rht_pick.sv]
`timescale 1ns / 1ps
module rht_pick import rht_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      find,
	input  logic      cand_vld,
	input  rht_cand_t cand,
	output logic      busy,
	output rht_best_t best
);

	logic                  vld_s2;
	rht_cand_t             c_s2;
	logic                  vld_s3;
	rht_cand_t             c_s3;
	logic [AREA_BITS-1:0]  area_s3;

	logic                  best_hit_q;
	logic [COORD_BITS-1:0] best_w_q;
	logic [COORD_BITS-1:0] best_h_q;
	logic [AREA_BITS-1:0]  best_area_q;
	logic [IDX_BITS-1:0]   best_idx_q;
	logic [TAG_BITS-1:0]   best_tag_q;

	logic                  smaller;
	logic                  upd;

	always_comb begin
		if (c_s3.w == best_w_q) begin
			smaller = c_s3.h < best_h_q;
		end else if (c_s3.h == best_h_q) begin
			smaller = c_s3.w < best_w_q;
		end else begin
			smaller = area_s3 < best_area_q;
		end
		upd = vld_s3 && c_s3.hit && (!best_hit_q || (!find && smaller));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			best_hit_q <= 1'b0;
		end else begin
			vld_s2 <= cand_vld;
			vld_s3 <= vld_s2;
			if (start) begin
				best_hit_q <= 1'b0;
			end else if (upd) begin
				best_hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		c_s2    <= cand;
		c_s3    <= c_s2;
		area_s3 <= AREA_BITS'(c_s2.w) * AREA_BITS'(c_s2.h);
		if (upd) begin
			best_w_q    <= c_s3.w;
			best_h_q    <= c_s3.h;
			best_area_q <= area_s3;
			best_idx_q  <= c_s3.idx;
			best_tag_q  <= c_s3.tag;
		end
	end

	assign busy     = vld_s2 || vld_s3;
	assign best.hit = best_hit_q;
	assign best.idx = best_idx_q;
	assign best.tag = best_tag_q;

endmodule

[rtl/rect_hit_test_table.sv]
// Write and remove: the result register loads from the finish state once it is free.
// Hit-test and find: one table entry read per cycle from the rectangle RAM,
// passing the read register and the pick stages s2 and s3 before the finish state.
// One item at a time: the next item is taken the cycle after the result loads,
// so no new item is taken before the current result loads; a stalled result delays it.
// Reset clears the valid bits and control at once; rectangle RAM is not cleared.
`timescale 1ns / 1ps
module rect_hit_test_table import rht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  rht_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rht_rsp_t rsp
);

	rht_state_t state_q, state_d;

	rht_entry_t mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [IDX_BITS:0]            cnt_q;
	logic                         scan_q;
	logic                         find_q;
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic [TAG_BITS-1:0]          qtag_q;
	logic [SLOT_BITS-1:0]         ack_slot_q;

	logic                vld_s1;
	rht_entry_t          rd_s1;
	logic                sv_s1;
	logic [IDX_BITS-1:0] idx_s1;

	logic     rsp_valid_q;
	rht_rsp_t rsp_q;

	logic                  accept;
	logic                  is_scan;
	logic                  in_range;
	logic [IDX_BITS-1:0]   wr_addr;
	logic                  issue;
	logic                  load_rsp;
	logic                  pick_busy;
	logic                  contains;
	logic [COORD_BITS-1:0] dw;
	logic [COORD_BITS-1:0] dh;
	rht_cand_t             cand;
	rht_best_t             best;
	rht_entry_t            wr_entry;
	rht_rsp_t              rsp_d;

	always_comb begin
		req_ready = state_q == ST_IDLE;
		accept    = req_valid && req_ready;
		is_scan   = req.opcode inside {OP_HIT, OP_FIND};
		in_range  = int'(req.slot) < TABLE_ENTRIES;
		wr_addr   = IDX_BITS'(req.slot);
		issue     = (state_q == ST_SCAN) && (cnt_q < (IDX_BITS + 1)'(TABLE_ENTRIES));
		load_rsp  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = is_scan ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (!issue && !vld_s1 && !pick_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_rsp) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		wr_entry.left_edge   = req.left_edge;
		wr_entry.top_edge    = req.top_edge;
		wr_entry.right_edge  = req.right_edge;
		wr_entry.bottom_edge = req.bottom_edge;
		wr_entry.tag         = req.entry_tag;

		contains = (px_q >= rd_s1.left_edge) && (px_q <= rd_s1.right_edge) &&
			(py_q >= rd_s1.top_edge) && (py_q <= rd_s1.bottom_edge);
		dw = rd_s1.right_edge - rd_s1.left_edge;
		dh = rd_s1.bottom_edge - rd_s1.top_edge;
		cand.hit = sv_s1 && (find_q ? (rd_s1.tag == qtag_q) : contains);
		cand.w   = dw;
		cand.h   = dh;
		cand.idx = idx_s1;
		cand.tag = rd_s1.tag;

		if (scan_q) begin
			rsp_d.found      = best.hit;
			rsp_d.match_slot = best.hit ? SLOT_BITS'(best.idx) : '0;
			rsp_d.match_tag  = best.hit ? best.tag : '0;
		end else begin
			rsp_d.found      = 1'b1;
			rsp_d.match_slot = ack_slot_q;
			rsp_d.match_tag  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept && in_range && (req.opcode == OP_WRITE)) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (accept && in_range && (req.opcode == OP_REMOVE)) begin
				valid_q[wr_addr] <= 1'b0;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scan_q     <= is_scan;
			find_q     <= req.opcode == OP_FIND;
			px_q       <= req.point_x;
			py_q       <= req.point_y;
			qtag_q     <= req.query_tag;
			ack_slot_q <= req.slot;
		end
		if (accept && in_range && (req.opcode == OP_WRITE)) begin
			mem[wr_addr] <= wr_entry;
		end
		if (issue) begin
			rd_s1  <= mem[cnt_q[IDX_BITS-1:0]];
			sv_s1  <= valid_q[cnt_q[IDX_BITS-1:0]];
			idx_s1 <= cnt_q[IDX_BITS-1:0];
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	rht_pick u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && is_scan),
		.find     (find_q),
		.cand_vld (vld_s1),
		.cand     (cand),
		.busy     (pick_busy),
		.best     (best)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/rht_chk.sv]
`timescale 1ns / 1ps
`include "rect_hit_test_table_defines.svh"
module rht_chk import rht_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input rht_rsp_t rsp
);

	`RHT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp), "stalled item changed")
	`RHT_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp.found,
		rsp.match_slot == '0 && rsp.match_tag == '0, "miss carries data")
	`RHT_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready,
		"second item taken while busy")
	`RHT_ASSERT_IMP(a_rsp_busy, $rose(rsp_valid), !$past(req_ready),
		"result without busy cycle")

endmodule

bind rect_hit_test_table rht_chk u_chk (.*);

[test/rect_hit_test_table_checker.sv]
`timescale 1ns / 1ps
module rect_hit_test_table_checker import rht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_ready,
	input  rht_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_ready,
	input  rht_rsp_t rsp,
	output int       mismatches,
	output int       outstanding
);

	rht_entry_t               shadow_rect [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] shadow_live;
	rht_rsp_t                 pending_rsp_q [$];
	int                       err_cnt = 0;

	function automatic bit box_smaller(input longint wa, input longint ha,
			input longint wb, input longint hb);
		if (wa == wb)
			return ha < hb;
		if (ha == hb)
			return wa < wb;
		return (wa * ha) < (wb * hb);
	endfunction

	function automatic rht_rsp_t table_response(input rht_req_t item);
		rht_rsp_t res;
		longint   px, py, lx, ty, rx, by, w, h, best_w, best_h;
		bit       hit;
		int       best;
		res    = '0;
		hit    = 1'b0;
		best   = 0;
		best_w = 0;
		best_h = 0;
		case (item.opcode)
			OP_WRITE, OP_REMOVE: begin
				if (item.slot < TABLE_ENTRIES) begin
					if (item.opcode == OP_WRITE) begin
						shadow_rect[item.slot].left_edge   = item.left_edge;
						shadow_rect[item.slot].top_edge    = item.top_edge;
						shadow_rect[item.slot].right_edge  = item.right_edge;
						shadow_rect[item.slot].bottom_edge = item.bottom_edge;
						shadow_rect[item.slot].tag         = item.entry_tag;
						shadow_live[item.slot]             = 1'b1;
					end else begin
						shadow_live[item.slot] = 1'b0;
					end
				end
				res.found      = 1'b1;
				res.match_slot = item.slot;
				res.match_tag  = '0;
				return res;
			end
			OP_HIT: begin
				px = $signed(item.point_x);
				py = $signed(item.point_y);
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (shadow_live[i]) begin
						lx = $signed(shadow_rect[i].left_edge);
						ty = $signed(shadow_rect[i].top_edge);
						rx = $signed(shadow_rect[i].right_edge);
						by = $signed(shadow_rect[i].bottom_edge);
						if (px >= lx && py >= ty && px <= rx && py <= by) begin
							w = rx - lx;
							h = by - ty;
							if (!hit || box_smaller(w, h, best_w, best_h)) begin
								hit    = 1'b1;
								best   = i;
								best_w = w;
								best_h = h;
							end
						end
					end
				end
			end
			default: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (!hit && shadow_live[i] && shadow_rect[i].tag == item.query_tag) begin
						hit  = 1'b1;
						best = i;
					end
				end
			end
		endcase
		if (hit) begin
			res.found      = 1'b1;
			res.match_slot = best[SLOT_BITS-1:0];
			res.match_tag  = shadow_rect[best].tag;
		end
		return res;
	endfunction

	always @(posedge clk) begin : watch
		rht_rsp_t want;
		if (!arst_n) begin
			shadow_live = '0;
			pending_rsp_q.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp_q.size() == 0) begin
					$display("%0t: unexpected result found=%b slot=%0d tag=%h",
						$time, rsp.found, rsp.match_slot, rsp.match_tag);
					err_cnt++;
				end else begin
					want = pending_rsp_q.pop_front();
					if (rsp.found !== want.found) begin
						$display("%0t: found expected %b actual %b",
							$time, want.found, rsp.found);
						err_cnt++;
					end
					if (rsp.match_slot !== want.match_slot) begin
						$display("%0t: match_slot expected %0d actual %0d",
							$time, want.match_slot, rsp.match_slot);
						err_cnt++;
					end
					if (rsp.match_tag !== want.match_tag) begin
						$display("%0t: match_tag expected %h actual %h",
							$time, want.match_tag, rsp.match_tag);
						err_cnt++;
					end
				end
			end
			if (req_valid && req_ready)
				pending_rsp_q.push_back(table_response(req));
		end
		mismatches  <= err_cnt;
		outstanding <= pending_rsp_q.size();
	end

endmodule

[test/rect_hit_test_table_tb.sv]
`timescale 1ns / 1ps
module rect_hit_test_table_tb;
	import rht_pkg::*;

	localparam int ITEM_COUNT   = 450;
	localparam int QUIET_TAIL   = 60;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	rht_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	rht_rsp_t rsp;
	int       mismatches;
	int       outstanding;
	bit       quiet      = 1'b0;
	int       cycle_cnt  = 0;
	int       stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rect_hit_test_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	rect_hit_test_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// stall the result side in bursts
	always @(posedge clk) begin
		if (quiet) begin
			rsp_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 15) begin
			stall_left = $urandom_range(1, 10) - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		int c;
		if ($urandom_range(0, 9) < 6) begin
			c = $urandom_range(0, 128);
			c = c - 64;
		end else begin
			c = $urandom;
		end
		return c[COORD_BITS-1:0];
	endfunction

	function automatic logic [TAG_BITS-1:0] rand_tag();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 15);
		return $urandom;
	endfunction

	function automatic rht_req_t random_item();
		rht_req_t                     item;
		logic signed [COORD_BITS-1:0] tmp;
		int                           pick;
		item = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 40)
			item.opcode = OP_WRITE;
		else if (pick < 55)
			item.opcode = OP_REMOVE;
		else if (pick < 80)
			item.opcode = OP_HIT;
		else
			item.opcode = OP_FIND;
		if ($urandom_range(0, 9) < 8) begin
			item.left_edge   = rand_coord();
			item.top_edge    = rand_coord();
			item.right_edge  = rand_coord();
			item.bottom_edge = rand_coord();
			item.point_x     = rand_coord();
			item.point_y     = rand_coord();
			item.entry_tag   = rand_tag();
			item.query_tag   = rand_tag();
			// keep most rectangles well-formed
			if ($urandom_range(0, 9) < 8) begin
				if (item.right_edge < item.left_edge) begin
					tmp             = item.left_edge;
					item.left_edge  = item.right_edge;
					item.right_edge = tmp;
				end
				if (item.bottom_edge < item.top_edge) begin
					tmp              = item.top_edge;
					item.top_edge    = item.bottom_edge;
					item.bottom_edge = tmp;
				end
			end
		end
		return item;
	endfunction

	function automatic rht_req_t mk(input logic [OPC_BITS-1:0] op, input int s,
			input int lx, input int ty, input int rx, input int by,
			input logic [TAG_BITS-1:0] etag, input int px, input int py,
			input logic [TAG_BITS-1:0] qtag);
		rht_req_t item;
		item.opcode      = op;
		item.slot        = s[SLOT_BITS-1:0];
		item.left_edge   = lx[COORD_BITS-1:0];
		item.top_edge    = ty[COORD_BITS-1:0];
		item.right_edge  = rx[COORD_BITS-1:0];
		item.bottom_edge = by[COORD_BITS-1:0];
		item.entry_tag   = etag;
		item.point_x     = px[COORD_BITS-1:0];
		item.point_y     = py[COORD_BITS-1:0];
		item.query_tag   = qtag;
		return item;
	endfunction

	task automatic send_item(input rht_req_t item);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < 25)
			gap = $urandom_range(1, 10);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (!(req_valid && req_ready));
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_REMOVE, 5, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_WRITE, 0, -524288, -524288, 524287, 524287,
			32'hFFFF_FFFF, 0, 0, 0));
		send_item(mk(OP_WRITE, 63, 0, 0, 16, 16, 0, 0, 0, 0));
		send_item(mk(OP_WRITE, 10, 100, 100, 50, 200, 32'h1234_5678, 0, 0, 0));
		send_item(mk(OP_WRITE, 20, 0, 0, 16, 32, 20, 0, 0, 0));
		send_item(mk(OP_WRITE, 21, 0, 0, 32, 8, 21, 0, 0, 0));
		send_item(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 16, 16, 0));
		send_item(mk(OP_HIT, 0, 0, 0, 0, 0, 0, -524288, -524288, 0));
		send_item(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 524287, 524287, 0));
		send_item(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 75, 150, 0));
		send_item(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 17, 0, 0));
		send_item(mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send_item(mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 32'h1234_5678));
		send_item(mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_WRITE, 30, 1, 1, 2, 2, 0, 0, 0, 0));
		send_item(mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_REMOVE, 30, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 524287, 524287, 0));
		send_item(mk(OP_WRITE, 0, 5, 5, 5, 5, 5, 0, 0, 0));
		send_item(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 5, 5, 0));

		for (int n = 0; n < ITEM_COUNT; n++) begin
			if (n == ITEM_COUNT / 2)
				wait_idle();
			if (n == ITEM_COUNT - QUIET_TAIL)
				quiet <= 1'b1;
			send_item(random_item());
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
